// ===== hdl/msbc_pkg.sv =====
// Shared constants, register indexes and types for the marching-squares block classifier.
`timescale 1ns / 1ps

package msbc_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 4096;
    localparam int BLOCK       = 3;
    localparam int MIN_SIZE    = 3;
    localparam int STORE_DEPTH = MAX_WIDTH / BLOCK;

    localparam int PIX_W      = 8;
    localparam int THR_W      = 8;
    localparam int CODE_W     = 4;
    localparam int W_W        = 11;
    localparam int H_W        = 13;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int BC_W       = $clog2(STORE_DEPTH);
    localparam int BR_W       = $clog2(MAX_HEIGHT / BLOCK);
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 13;
    localparam int OUT_DATA_W = 24;

    localparam logic [THR_W-1:0] THRESHOLD_RST = 8'd128;
    localparam logic [W_W-1:0]   WIDTH_RST     = 11'd640;
    localparam logic [H_W-1:0]   HEIGHT_RST    = 13'd480;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_WIDTH     = 2'd1,
        CFG_HEIGHT    = 2'd2
    } cfg_idx_t;

    // Role of the current pixel within its 3x3 block, plus block position.
    typedef struct packed {
        logic            top_left;
        logic            top_right;
        logic            bot_left;
        logic            bot_right;
        logic            last;
        logic [BC_W-1:0] col_blk;
        logic [BR_W-1:0] row_blk;
    } pos_t;

endpackage

// ===== hdl/msbc_corner_store.sv =====
// Line store of the two top-corner bits of each block column, registered read.
`timescale 1ns / 1ps

module msbc_corner_store (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [msbc_pkg::BC_W-1:0]  wr_addr,
    input  logic [1:0]                 wr_data,
    input  logic                       rd_en,
    input  logic [msbc_pkg::BC_W-1:0]  rd_addr,
    output logic [1:0]                 rd_data
);

    logic [1:0] mem [msbc_pkg::STORE_DEPTH];
    logic [1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/msbc_pos_tracker.sv =====
// Raster position counters with mod-3 phases and block indexes; flags each pixel's corner role.
`timescale 1ns / 1ps

module msbc_pos_tracker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic [msbc_pkg::W_W-1:0]      frame_width,
    input  logic [msbc_pkg::H_W-1:0]      frame_height,
    output msbc_pkg::pos_t                pos
);

    localparam int COL_W = msbc_pkg::COL_W;
    localparam int ROW_W = msbc_pkg::ROW_W;
    localparam int BC_W  = msbc_pkg::BC_W;
    localparam int BR_W  = msbc_pkg::BR_W;
    localparam int W_W   = msbc_pkg::W_W;
    localparam int H_W   = msbc_pkg::H_W;

    logic [COL_W-1:0] col_cnt_reg, col_cnt_next;
    logic [1:0]       col_ph_reg, col_ph_next;
    logic [BC_W-1:0]  col_blk_reg, col_blk_next;
    logic [ROW_W-1:0] row_cnt_reg, row_cnt_next;
    logic [1:0]       row_ph_reg, row_ph_next;
    logic [BR_W-1:0]  row_blk_reg, row_blk_next;

    logic             wrap_c, wrap_r, wrap_c2, wrap_r2;
    logic [COL_W-1:0] c_cnt, c_base;
    logic [1:0]       c_ph, r1_ph, r_ph;
    logic [BC_W-1:0]  c_blk;
    logic [ROW_W:0]   r1_cnt, r_inc, r2_cnt;
    logic [BR_W-1:0]  r1_blk, r_blk;
    logic [ROW_W-1:0] r_cnt, r_base;
    logic [COL_W:0]   c_inc;
    logic [W_W:0]     c_end;
    logic [H_W:0]     r_end;
    logic             col_ok, row_ok, blk_ok;

    always_comb begin
        // a size change can leave the counters outside the frame
        wrap_c = {1'b0, col_cnt_reg} >= frame_width;
        c_cnt  = wrap_c ? '0 : col_cnt_reg;
        c_ph   = wrap_c ? 2'd0 : col_ph_reg;
        c_blk  = wrap_c ? '0 : col_blk_reg;

        r_inc  = {1'b0, row_cnt_reg} + (ROW_W+1)'(1);
        r1_cnt = wrap_c ? r_inc : {1'b0, row_cnt_reg};
        r1_ph  = (wrap_c && row_ph_reg == 2'd2) ? 2'd0
               : (wrap_c ? row_ph_reg + 2'd1 : row_ph_reg);
        r1_blk = (wrap_c && row_ph_reg == 2'd2) ? row_blk_reg + BR_W'(1) : row_blk_reg;

        wrap_r = r1_cnt >= (ROW_W+1)'(frame_height);
        r_cnt  = wrap_r ? '0 : r1_cnt[ROW_W-1:0];
        r_ph   = wrap_r ? 2'd0 : r1_ph;
        r_blk  = wrap_r ? '0 : r1_blk;

        c_base = c_cnt - COL_W'(c_ph);
        c_end  = (W_W+1)'(c_base) + (W_W+1)'(msbc_pkg::BLOCK);
        col_ok = c_end <= {1'b0, frame_width};
        r_base = r_cnt - ROW_W'(r_ph);
        r_end  = (H_W+1)'(r_base) + (H_W+1)'(msbc_pkg::BLOCK);
        row_ok = r_end <= {1'b0, frame_height};
        blk_ok = col_ok && row_ok;

        pos.top_left  = blk_ok && r_ph == 2'd0 && c_ph == 2'd0;
        pos.top_right = blk_ok && r_ph == 2'd0 && c_ph == 2'd2;
        pos.bot_left  = blk_ok && r_ph == 2'd2 && c_ph == 2'd0;
        pos.bot_right = blk_ok && r_ph == 2'd2 && c_ph == 2'd2;
        pos.last      = (c_end + (W_W+1)'(msbc_pkg::BLOCK) > {1'b0, frame_width})
                     && (r_end + (H_W+1)'(msbc_pkg::BLOCK) > {1'b0, frame_height});
        pos.col_blk   = c_blk;
        pos.row_blk   = r_blk;

        // position of the following pixel
        c_inc   = {1'b0, c_cnt} + (COL_W+1)'(1);
        wrap_c2 = c_inc >= frame_width;
        r2_cnt  = {1'b0, r_cnt} + (ROW_W+1)'(1);
        wrap_r2 = r2_cnt >= (ROW_W+1)'(frame_height);

        if (wrap_c2) begin
            col_cnt_next = '0;
            col_ph_next  = 2'd0;
            col_blk_next = '0;
            if (wrap_r2) begin
                row_cnt_next = '0;
                row_ph_next  = 2'd0;
                row_blk_next = '0;
            end else begin
                row_cnt_next = r2_cnt[ROW_W-1:0];
                row_ph_next  = (r_ph == 2'd2) ? 2'd0 : r_ph + 2'd1;
                row_blk_next = (r_ph == 2'd2) ? r_blk + BR_W'(1) : r_blk;
            end
        end else begin
            col_cnt_next = c_inc[COL_W-1:0];
            col_ph_next  = (c_ph == 2'd2) ? 2'd0 : c_ph + 2'd1;
            col_blk_next = (c_ph == 2'd2) ? c_blk + BC_W'(1) : c_blk;
            row_cnt_next = r_cnt;
            row_ph_next  = r_ph;
            row_blk_next = r_blk;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            col_ph_reg  <= 2'd0;
            col_blk_reg <= '0;
            row_cnt_reg <= '0;
            row_ph_reg  <= 2'd0;
            row_blk_reg <= '0;
        end else if (advance) begin
            col_cnt_reg <= col_cnt_next;
            col_ph_reg  <= col_ph_next;
            col_blk_reg <= col_blk_next;
            row_cnt_reg <= row_cnt_next;
            row_ph_reg  <= row_ph_next;
            row_blk_reg <= row_blk_next;
        end
    end

endmodule

// ===== hdl/marching_square_block_classifier.sv =====
// Marching-squares block classifier: pixel stream in, one corner case code per whole 3x3 block out.
// A code is registered in the code stage with the bottom-right pixel, then in the output register.
// Throughput: one pixel per cycle; set by the position counters and the corner store's one
// read port, with a single write port for the first-row top corners; output stalls hold the input.
// Reset (aresetn low, synchronous): counters, pipeline and output valids clear, registers
// return to threshold 128, width 640, height 480; the corner store is not cleared.
`timescale 1ns / 1ps

module marching_square_block_classifier (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [msbc_pkg::PIX_W-1:0]        s_tdata,   // [7:0] pixel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [msbc_pkg::OUT_DATA_W-1:0]   m_tdata,   // [3:0] case_code, [12:4] block_column,
                                                         // [23:13] block_row
    output logic                              m_tlast,
    input  logic                              cfg_wen,
    input  logic [msbc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [msbc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int W_W  = msbc_pkg::W_W;
    localparam int H_W  = msbc_pkg::H_W;
    localparam int BC_W = msbc_pkg::BC_W;
    localparam int BR_W = msbc_pkg::BR_W;

    logic [msbc_pkg::THR_W-1:0] thresh_reg, thresh_next;
    logic [W_W-1:0]             width_reg, width_next;
    logic [H_W-1:0]             height_reg, height_next;
    logic [W_W-1:0]             width_in;
    logic [H_W-1:0]             height_in;

    msbc_pkg::pos_t pos;
    logic           s_accept, px_bit, out_free, stg1_free;
    logic           mem_wr, mem_rd;
    logic [1:0]     mem_rdata;

    logic tl_reg, bl_reg;
    logic stg1_valid_reg, stg1_valid_next;
    logic out_valid_reg, out_valid_next;

    logic            stg1_br_reg, stg1_bl_reg, stg1_last_reg;
    logic [BC_W-1:0] stg1_col_reg;
    logic [BR_W-1:0] stg1_row_reg;

    logic [msbc_pkg::CODE_W-1:0] out_code_reg;
    logic [BC_W-1:0]             out_col_reg;
    logic [BR_W-1:0]             out_row_reg;
    logic                        out_last_reg;

    // configuration, sizes clamped on write
    always_comb begin
        thresh_next = thresh_reg;
        width_next  = width_reg;
        height_next = height_reg;
        width_in    = cfg_wdata[W_W-1:0];
        height_in   = cfg_wdata[H_W-1:0];
        if (width_in < W_W'(msbc_pkg::MIN_SIZE)) begin
            width_in = W_W'(msbc_pkg::MIN_SIZE);
        end else if (width_in > W_W'(msbc_pkg::MAX_WIDTH)) begin
            width_in = W_W'(msbc_pkg::MAX_WIDTH);
        end
        if (height_in < H_W'(msbc_pkg::MIN_SIZE)) begin
            height_in = H_W'(msbc_pkg::MIN_SIZE);
        end else if (height_in > H_W'(msbc_pkg::MAX_HEIGHT)) begin
            height_in = H_W'(msbc_pkg::MAX_HEIGHT);
        end
        if (cfg_wen) begin
            unique case (cfg_addr)
                msbc_pkg::CFG_THRESHOLD: thresh_next = cfg_wdata[msbc_pkg::THR_W-1:0];
                msbc_pkg::CFG_WIDTH:     width_next  = width_in;
                msbc_pkg::CFG_HEIGHT:    height_next = height_in;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= msbc_pkg::THRESHOLD_RST;
            width_reg  <= msbc_pkg::WIDTH_RST;
            height_reg <= msbc_pkg::HEIGHT_RST;
        end else begin
            thresh_reg <= thresh_next;
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    msbc_pos_tracker u_tracker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (s_accept),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .pos          (pos)
    );

    assign out_free  = !out_valid_reg || m_tready;
    assign stg1_free = !stg1_valid_reg || out_free;
    assign s_tready  = stg1_free;
    assign s_accept  = s_tvalid && s_tready;
    assign px_bit    = s_tdata > thresh_reg;

    // top row writes both corners at top-right; bottom row reads them at bottom-right.
    // The two never meet on one entry in one cycle, so no forwarding is needed.
    assign mem_wr = s_accept && pos.top_right;
    assign mem_rd = s_accept && pos.bot_right;

    msbc_corner_store u_store (
        .aclk    (aclk),
        .wr_en   (mem_wr),
        .wr_addr (pos.col_blk),
        .wr_data ({tl_reg, px_bit}),
        .rd_en   (mem_rd),
        .rd_addr (pos.col_blk),
        .rd_data (mem_rdata)
    );

    always_comb begin
        stg1_valid_next = stg1_valid_reg && !out_free;
        if (s_accept) begin
            stg1_valid_next = pos.bot_right;
        end
        out_valid_next = out_valid_reg && !m_tready;
        if (stg1_valid_reg && out_free) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg1_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            tl_reg         <= 1'b0;
            bl_reg         <= 1'b0;
        end else begin
            stg1_valid_reg <= stg1_valid_next;
            out_valid_reg  <= out_valid_next;
            if (s_accept && pos.top_left) begin
                tl_reg <= px_bit;
            end
            if (s_accept && pos.bot_left) begin
                bl_reg <= px_bit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_rd) begin
            stg1_br_reg   <= px_bit;
            stg1_bl_reg   <= bl_reg;
            stg1_last_reg <= pos.last;
            stg1_col_reg  <= pos.col_blk;
            stg1_row_reg  <= pos.row_blk;
        end
        if (stg1_valid_reg && out_free) begin
            out_code_reg <= {mem_rdata, stg1_br_reg, stg1_bl_reg};
            out_col_reg  <= stg1_col_reg;
            out_row_reg  <= stg1_row_reg;
            out_last_reg <= stg1_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_row_reg, out_col_reg, out_code_reg};
    assign m_tlast  = out_last_reg;

    a_store_single_port_use: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_wr && mem_rd))
        else $error("corner store read and written in the same cycle");

    a_stage_from_read: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(stg1_valid_reg) |-> $past(mem_rd))
        else $error("code stage filled without a corner store read");

    a_stage_holds_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (stg1_valid_reg && !out_free) |-> !mem_rd)
        else $error("corner store read data overwritten while the code stage is stalled");

    a_column_in_store: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_col_reg < BC_W'(msbc_pkg::STORE_DEPTH)))
        else $error("block column beyond the corner store");

endmodule

// ===== tb/marching_square_block_classifier_tb.sv =====
// Self-checking testbench for the marching-squares block classifier: random pixel frames
// over many frame sizes and thresholds, codes predicted in the bench and compared in order.
`timescale 1ns / 1ps

module marching_square_block_classifier_tb;

    localparam int PIX_W       = msbc_pkg::PIX_W;
    localparam int THR_W       = msbc_pkg::THR_W;
    localparam int CODE_W      = msbc_pkg::CODE_W;
    localparam int W_W         = msbc_pkg::W_W;
    localparam int H_W         = msbc_pkg::H_W;
    localparam int BC_W        = msbc_pkg::BC_W;
    localparam int BR_W        = msbc_pkg::BR_W;
    localparam int CFG_ADDR_W  = msbc_pkg::CFG_ADDR_W;
    localparam int CFG_DATA_W  = msbc_pkg::CFG_DATA_W;
    localparam int OUT_DATA_W  = msbc_pkg::OUT_DATA_W;
    localparam int STORE_DEPTH = msbc_pkg::STORE_DEPTH;
    localparam int MIN_SIZE    = msbc_pkg::MIN_SIZE;
    localparam int MAX_WIDTH   = msbc_pkg::MAX_WIDTH;
    localparam int MAX_HEIGHT  = msbc_pkg::MAX_HEIGHT;

    localparam int CYCLE_LIMIT  = 300_000;
    localparam int RANDOM_ITEMS = 520;
    localparam int SETTLE_WAIT  = 4;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [BC_W-1:0]   col;
        logic [BR_W-1:0]   row;
        logic              last;
    } blk_code_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  cfg_wen   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // bench copy of the block's registers and position state
    logic [THR_W-1:0] thr_reg    = msbc_pkg::THRESHOLD_RST;
    logic [W_W-1:0]   width_reg  = msbc_pkg::WIDTH_RST;
    logic [H_W-1:0]   height_reg = msbc_pkg::HEIGHT_RST;
    int               pos_col    = 0;
    int               pos_row    = 0;
    logic [1:0]       corner_mem [STORE_DEPTH] = '{default: 2'b00};
    logic             bl_bit     = 1'b0;

    logic [PIX_W-1:0] pixel_q [$];
    blk_code_t        code_q [$];
    blk_code_t        seen_code;
    blk_code_t        due_code;
    int               gap_pct   = 12;
    int               err_cnt   = 0;
    int               cycle_cnt = 0;

    marching_square_block_classifier dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [7:0] pixel
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [3:0] case_code, [12:4] block_column, [23:13] block_row
        .m_tlast   (m_tlast),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) cycle_cnt <= cycle_cnt + 1;

    function automatic int fit_size(int v, int hi_lim);
        if (v < MIN_SIZE) return MIN_SIZE;
        if (v > hi_lim) return hi_lim;
        return v;
    endfunction

    function automatic int eff_width();
        return fit_size(int'(width_reg), MAX_WIDTH);
    endfunction

    function automatic int eff_height();
        return fit_size(int'(height_reg), MAX_HEIGHT);
    endfunction

    // advance the position by one pixel and queue the code if it closes a whole block
    function automatic void classify_pixel(logic [PIX_W-1:0] pix);
        int        w;
        int        h;
        int        bc;
        int        br;
        int        cph;
        int        rph;
        logic      lit;
        blk_code_t e;
        w   = eff_width();
        h   = eff_height();
        lit = (pix > thr_reg);
        if (pos_col >= w) begin
            pos_col = 0;
            pos_row++;
        end
        if (pos_row >= h) pos_row = 0;
        bc  = pos_col / 3;
        br  = pos_row / 3;
        cph = pos_col % 3;
        rph = pos_row % 3;
        if (bc < w / 3 && bc < STORE_DEPTH && br < h / 3) begin
            if (rph == 0) begin
                if (cph == 0) corner_mem[bc][1] = lit;
                else if (cph == 2) corner_mem[bc][0] = lit;
            end else if (rph == 2) begin
                if (cph == 0) begin
                    bl_bit = lit;
                end else if (cph == 2) begin
                    e.code = {corner_mem[bc], lit, bl_bit};
                    e.col  = BC_W'(bc);
                    e.row  = BR_W'(br);
                    e.last = (bc + 1 == w / 3) && (br + 1 == h / 3);
                    code_q.push_back(e);
                end
            end
        end
        pos_col++;
        if (pos_col >= w) begin
            pos_col = 0;
            pos_row++;
            if (pos_row >= h) pos_row = 0;
        end
    endfunction

    // pixels still needed to reach the start of a block row (or of a frame)
    function automatic int pixels_to_boundary(bit whole_frame);
        int w;
        int h;
        int c;
        int r;
        int n;
        w = eff_width();
        h = eff_height();
        c = pos_col;
        r = pos_row;
        n = 0;
        if (c >= w) begin
            c = 0;
            r++;
        end
        if (r >= h) r = 0;
        while (!(c == 0 && (whole_frame ? r == 0 : r % 3 == 0))) begin
            c++;
            if (c >= w) begin
                c = 0;
                r++;
                if (r >= h) r = 0;
            end
            n++;
        end
        return n;
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 4))
            0: return thr_reg;
            1: return thr_reg + 8'd1;
            2: return $urandom_range(0, 1) ? 8'd0 : 8'd255;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // input side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) classify_pixel(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (pixel_q.size() > 0 && $urandom_range(0, 99) >= gap_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pixel_q.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= gap_pct);
            if (m_tvalid && m_tready) begin
                seen_code = {m_tdata[3:0], m_tdata[12:4], m_tdata[23:13], m_tlast};
                if (code_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("%0t: unexpected transfer code %h col %0d row %0d last %b",
                                 $realtime, seen_code.code, seen_code.col, seen_code.row,
                                 seen_code.last);
                end else begin
                    due_code = code_q.pop_front();
                    if (seen_code !== due_code) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("%0t: exp %h/%0d/%0d/%b got %h/%0d/%0d/%b", $realtime,
                                     due_code.code, due_code.col, due_code.row, due_code.last,
                                     seen_code.code, seen_code.col, seen_code.row,
                                     seen_code.last);
                    end
                end
            end
        end
    end

    // wait until every pixel is in and every code is out, then let the pipeline empty
    task automatic settle();
        while (pixel_q.size() != 0 || s_tvalid || code_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);
    endtask

    task automatic send_pixels(int n);
        @(negedge aclk);
        repeat (n) pixel_q.push_back(pick_pixel());
    endtask

    task automatic realign(bit whole_frame);
        int n;
        n = pixels_to_boundary(whole_frame);
        if (n > 0) begin
            send_pixels(n);
            settle();
        end
    endtask

    task automatic set_config(int thr, int w, int h);
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_addr  <= msbc_pkg::CFG_THRESHOLD;
        cfg_wdata <= CFG_DATA_W'(thr[THR_W-1:0]);
        thr_reg    = thr[THR_W-1:0];
        @(posedge aclk);
        cfg_addr  <= msbc_pkg::CFG_WIDTH;
        cfg_wdata <= CFG_DATA_W'(w[W_W-1:0]);
        width_reg  = w[W_W-1:0];
        @(posedge aclk);
        cfg_addr  <= msbc_pkg::CFG_HEIGHT;
        cfg_wdata <= CFG_DATA_W'(h[H_W-1:0]);
        height_reg = h[H_W-1:0];
        @(posedge aclk);
        cfg_wen   <= 1'b0;
    endtask

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        logic [PIX_W-1:0] dir_pix [27];
        int               sent;
        int               phase;
        int               thr;
        int               w;
        int               h;
        int               n;
        bit               mid;
        // three 3x3 frames: corners at raster slots 0, 2, 6 and 8
        dir_pix = '{8'd255, 8'd100, 8'd100, 8'd101, 8'd0,   8'd255, 8'd101, 8'd255, 8'd0,
                    8'd100, 8'd0,   8'd101, 8'd255, 8'd100, 8'd101, 8'd0,   8'd101, 8'd255,
                    8'd1,   8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd128, 8'd0,   8'd1};
        sent  = 0;
        phase = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: pixel at and just above threshold, both extremes, the lowest threshold
        set_config(100, 3, 3);
        @(negedge aclk);
        for (int i = 0; i < 18; i++) pixel_q.push_back(dir_pix[i]);
        settle();
        set_config(0, 3, 3);
        @(negedge aclk);
        for (int i = 18; i < 27; i++) pixel_q.push_back(dir_pix[i]);
        settle();

        // two frames with no idling on either side
        gap_pct = 0;
        set_config($urandom_range(0, 255), 12, 9);
        send_pixels(12 * 9 * 2);
        settle();
        gap_pct = 12;
        // leave a tall frame part way, sizes then change at a block-row start
        set_config($urandom_range(0, 255), 1, 8191);
        send_pixels(3 * 3 * 5);
        settle();

        while (sent < RANDOM_ITEMS) begin
            mid = (phase == 0) || ($urandom_range(0, 9) < 3);
            sent += pixels_to_boundary(!mid);
            realign(!mid);
            case ($urandom_range(0, 5))
                0: thr = 0;
                1: thr = 255;
                default: thr = $urandom_range(0, 255);
            endcase
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
            set_config(thr, w, h);
            n = eff_width() * eff_height() * $urandom_range(1, 2)
              + eff_width() * 3 * $urandom_range(0, eff_height() / 3);
            gap_pct = ($urandom_range(0, 7) == 0) ? 0 : 12;
            send_pixels(n);
            sent += n;
            settle();
            phase++;
        end

        gap_pct = 12;
        settle();
        repeat (10) @(posedge aclk);
        if (err_cnt == 0 && code_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/msbc_pkg.sv
hdl/msbc_corner_store.sv
hdl/msbc_pos_tracker.sv
hdl/marching_square_block_classifier.sv
tb/marching_square_block_classifier_tb.sv
